### hdl/alr_pkg.sv
package alr_pkg;

  localparam int unsigned ADDR_WIDTH   = 20;
  localparam int unsigned SAMPLE_WIDTH = 24;
  localparam int unsigned GAIN_WIDTH   = 16;
  localparam int unsigned MEM_DEPTH    = 1 << ADDR_WIDTH;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_REC   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [SAMPLE_WIDTH-1:0]  sample_in;
    logic                     flag_value;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0]  sample_out;
    logic                     is_playing;
    logic                     is_recording;
    logic                     has_loop;
    logic [ADDR_WIDTH-1:0]    position;
  } out_t;

endpackage

### hdl/audio_loop_recorder_core.sv
// a sample tick passes the read, multiply and push states on its way to the output
//   register, any other command straight to push; push waits on a stalled output
// a new command is taken only in the idle state, once the last one is pushed; each
//   tick does the read, modify and write back of the single-port loop memory
// reset and clear: a sweep writes zero to all 2^ADDR_WIDTH memory words, one a
//   cycle, with no word taken in; gain writes are accepted throughout
module audio_loop_recorder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  alr_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output alr_pkg::out_t                       out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [alr_pkg::GAIN_WIDTH-1:0]      cfg_data_i
);

  localparam int unsigned AW = alr_pkg::ADDR_WIDTH;
  localparam int unsigned SW = alr_pkg::SAMPLE_WIDTH;
  localparam int unsigned GW = alr_pkg::GAIN_WIDTH;
  localparam int unsigned PW = SW + GW + 1;

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;

  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       sweep_q;
  logic [AW-1:0]       pos_q, pos_d;
  logic [AW-1:0]       len_q, len_d;
  logic                play_q, play_d;
  logic                rec_q, rec_d;
  logic                has_q, has_d;
  logic                clr_q, clr_d;
  logic                tick_play_q;
  logic [GW-1:0]       gain_q;
  alr_pkg::in_t        item_q;
  logic [SW-1:0]       rdata_q;
  logic signed [SW-1:0] stored_q, stored_d;
  logic signed [PW-1:0] prod_q;
  logic                out_valid_q;
  alr_pkg::out_t       out_data_q;

  logic [SW-1:0]       mem_q [alr_pkg::MEM_DEPTH];
  logic                mem_re, mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SW-1:0]       mem_wdata;

  logic                in_fire, push;
  logic signed [SW:0]  sum;
  logic [AW:0]         pos_inc;
  logic signed [PW:0]  rounded;
  logic signed [SW+2:0] scaled;
  logic signed [SW-1:0] scaled_sat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign push        = (state_q == ST_PUSH) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // overdub sum with saturation while recording, else the read sample unchanged
  assign sum = {rdata_q[SW-1], rdata_q} + {item_q.sample_in[SW-1], item_q.sample_in};
  always_comb begin
    if (rec_q) begin
      if (sum[SW] != sum[SW-1]) begin
        stored_d = sum[SW] ? SMP_MIN : SMP_MAX;
      end else begin
        stored_d = sum[SW-1:0];
      end
    end else begin
      stored_d = rdata_q;
    end
  end

  // round half up, then saturate
  assign rounded = {prod_q[PW-1], prod_q} + (PW+1)'(1 << 14);
  assign scaled  = rounded[PW:15];
  always_comb begin
    if (scaled[SW+2:SW-1] == '0 || scaled[SW+2:SW-1] == '1) begin
      scaled_sat = scaled[SW-1:0];
    end else begin
      scaled_sat = scaled[SW+2] ? SMP_MIN : SMP_MAX;
    end
  end

  assign pos_inc = {1'b0, pos_q} + (AW+1)'(1);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    len_d     = len_q;
    play_d    = play_q;
    rec_d     = rec_q;
    has_d     = has_q;
    clr_d     = clr_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = stored_d;
    case (state_q)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_PUSH;
          case (in_data_i.cmd)
            alr_pkg::CMD_TICK: begin
              mem_re  = 1'b1;
              state_d = ST_READ;
            end
            alr_pkg::CMD_PLAY: begin
              play_d = in_data_i.flag_value;
              if (!in_data_i.flag_value) begin
                pos_d = '0;
              end
            end
            alr_pkg::CMD_REC: begin
              if (rec_q && !in_data_i.flag_value) begin
                has_d = 1'b1;
              end
              rec_d = in_data_i.flag_value;
            end
            alr_pkg::CMD_CLEAR: begin
              pos_d  = '0;
              len_d  = '0;
              play_d = 1'b0;
              rec_d  = 1'b0;
              has_d  = 1'b0;
              clr_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_MUL;
        mem_we  = rec_q;
        if (rec_q && !has_q && len_q != '1) begin
          len_d = len_q + AW'(1);
        end
        if (play_q || rec_q) begin
          pos_d = (pos_inc > {1'b0, len_d}) ? '0 : pos_inc[AW-1:0];
        end
      end
      ST_MUL: begin
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (push) begin
          state_d = clr_q ? ST_SWEEP : ST_IDLE;
          clr_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      pos_q       <= '0;
      len_q       <= '0;
      play_q      <= 1'b0;
      rec_q       <= 1'b0;
      has_q       <= 1'b0;
      clr_q       <= 1'b0;
      tick_play_q <= 1'b0;
      gain_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      play_q  <= play_d;
      rec_q   <= rec_d;
      has_q   <= has_d;
      clr_q   <= clr_d;
      if (state_q == ST_SWEEP) begin
        sweep_q <= sweep_q + AW'(1);
      end else begin
        sweep_q <= '0;
      end
      if (in_fire) begin
        tick_play_q <= 1'b0;
      end else if (state_q == ST_READ) begin
        tick_play_q <= play_q && has_q;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        gain_q <= cfg_data_i;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_READ) begin
      stored_q <= stored_d;
    end
    if (state_q == ST_MUL) begin
      prod_q <= stored_q * $signed({1'b0, gain_q});
    end
    if (push) begin
      out_data_q.sample_out   <= tick_play_q ? scaled_sat : '0;
      out_data_q.is_playing   <= play_q;
      out_data_q.is_recording <= rec_q;
      out_data_q.has_loop     <= has_q;
      out_data_q.position     <= pos_q;
    end
  end

  // loop memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[pos_q];
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= len_q)
    else $error("play position beyond loop length");

  a_silent_without_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !(out_data_o.has_loop && out_data_o.is_playing))
      |-> (out_data_o.sample_out == '0))
    else $error("playback sample without a playing loop");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.cmd == alr_pkg::CMD_CLEAR)
      |=> (pos_q == '0 && len_q == '0 && !has_q && clr_q))
    else $error("clear left loop state behind");

  a_sweep_idle_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (!play_q && !rec_q && !has_q))
    else $error("flags set during memory sweep");
`endif

endmodule
